// File: hw/rtl/line_offset_table_lookup_assert.svh
// Assertion macros for the line offset table RTL.
`ifndef LINE_OFFSET_TABLE_LOOKUP_ASSERT_SVH
`define LINE_OFFSET_TABLE_LOOKUP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LOTL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line offset table: implication check failed");

// Next-cycle implication, checked outside reset.
`define LOTL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line offset table: next-cycle check failed");

`endif

// File: hw/rtl/lotl_pkg.sv
// Shared constants and types for the line offset table lookup.
package lotl_pkg;

   localparam int MAX_LINES   = 4096;
   localparam int OFFSET_BITS = 24;
   localparam int IDX_W       = $clog2(MAX_LINES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int START_W     = OFFSET_BITS + 1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_ORDER = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

// File: hw/rtl/line_offset_table_lookup.sv
// Line offset table: sorted line-start store with binary-search line lookup.
// Append: finish state, then result register; table update at accept.
// Query: one start-table read per search step, set by the single RAM read port.
// One item in flight; a new beat is taken while the prior result waits.
// Synchronous reset: table holds line 1 at offset 0; RAM contents kept.
`include "line_offset_table_lookup_assert.svh"

module line_offset_table_lookup
   import lotl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_mode,
   input  logic [OFFSET_BITS-1:0] req_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [CNT_W-1:0]       rsp_line_number,
   output logic [START_W-1:0]     rsp_line_base,
   output logic [START_W-1:0]     rsp_line_last_byte,
   output logic                   rsp_end_known
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FIN
   } state_type;

   state_type              state_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [START_W-1:0]     newest_ff;
   logic                   is_query_ff;
   status_type             status_ff;
   logic [OFFSET_BITS-1:0] off_ff;
   logic [IDX_W-1:0]       lo_ff;
   logic [IDX_W-1:0]       hi_ff;
   logic [IDX_W-1:0]       mid_ff;
   logic [START_W-1:0]     lo_val_ff;
   logic [START_W-1:0]     next_val_ff;
   logic                   next_seen_ff;

   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [CNT_W-1:0]       rsp_line_number_ff;
   logic [START_W-1:0]     rsp_line_base_ff;
   logic [START_W-1:0]     rsp_line_last_byte_ff;
   logic                   rsp_end_known_ff;

   logic                   req_beat;
   logic                   out_free;
   logic [START_W-1:0]     app_start;
   logic                   app_order_bad;
   logic                   app_full;
   logic                   app_ok;
   logic [CNT_W-1:0]       cnt_m1;
   logic [IDX_W-1:0]       first_hi;
   logic [IDX_W-1:0]       first_mid;
   logic [START_W-1:0]     rd_data;
   logic                   le_hit;
   logic [IDX_W-1:0]       lo_in;
   logic [IDX_W-1:0]       hi_in;
   logic [IDX_W-1:0]       mid_in;
   logic                   converged;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;

   // midpoint rounded up: lo + (hi - lo + 1) / 2
   function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                                 input logic [IDX_W-1:0] hi);
      logic [IDX_W:0] span;
      span = {1'b0, hi} - {1'b0, lo} + {{IDX_W{1'b0}}, 1'b1};
      return lo + span[IDX_W:1];
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // append checks: order first, then capacity
   assign app_start     = {1'b0, req_offset} + {{OFFSET_BITS{1'b0}}, 1'b1};
   assign app_order_bad = (app_start <= newest_ff);
   assign app_full      = (count_ff >= CNT_W'(MAX_LINES));
   assign app_ok        = !app_order_bad && !app_full;

   // initial search window [0, count-1]
   assign cnt_m1    = count_ff - {{(CNT_W-1){1'b0}}, 1'b1};
   assign first_hi  = cnt_m1[IDX_W-1:0];
   assign first_mid = mid_of({IDX_W{1'b0}}, first_hi);

   // one search step per cycle on the returned entry
   assign le_hit    = (rd_data <= {1'b0, off_ff});
   assign lo_in     = le_hit ? mid_ff : lo_ff;
   assign hi_in     = le_hit ? hi_ff : (mid_ff - {{(IDX_W-1){1'b0}}, 1'b1});
   assign converged = (lo_in == hi_in);
   assign mid_in    = mid_of(lo_in, hi_in);

   // table read port: first probe at accept, then one probe per step
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = first_mid;
      if (state_ff == ST_IDLE) begin
         rd_en = req_beat && req_mode && (first_hi != '0);
      end else if (state_ff == ST_SEARCH) begin
         rd_en   = !converged;
         rd_addr = mid_in;
      end
   end

   lotl_ram #(
      .WIDTH (START_W),
      .DEPTH (MAX_LINES)
   ) u_start_table (
      .clock   (clock),
      .wr_en   (req_beat && !req_mode && app_ok),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (app_start),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer, table bookkeeping and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= {{(CNT_W-1){1'b0}}, 1'b1};
         newest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_beat) begin
                  is_query_ff  <= req_mode;
                  off_ff       <= req_offset;
                  lo_ff        <= '0;
                  hi_ff        <= first_hi;
                  mid_ff       <= first_mid;
                  lo_val_ff    <= '0;
                  next_seen_ff <= 1'b0;
                  status_ff    <= STATUS_OK;
                  if (req_mode) begin
                     state_ff <= (first_hi == '0) ? ST_FIN : ST_SEARCH;
                  end else begin
                     state_ff <= ST_FIN;
                     if (app_order_bad) begin
                        status_ff <= STATUS_ORDER;
                     end else if (app_full) begin
                        status_ff <= STATUS_FULL;
                     end else begin
                        count_ff  <= count_ff + {{(CNT_W-1){1'b0}}, 1'b1};
                        newest_ff <= app_start;
                     end
                  end
               end
            end
            ST_SEARCH: begin
               lo_ff  <= lo_in;
               hi_ff  <= hi_in;
               mid_ff <= mid_in;
               if (le_hit) begin
                  lo_val_ff <= rd_data;
               end else begin
                  next_val_ff  <= rd_data;
                  next_seen_ff <= 1'b1;
               end
               if (converged) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  state_ff              <= ST_IDLE;
                  rsp_valid_ff          <= 1'b1;
                  rsp_status_ff         <= status_ff;
                  rsp_line_number_ff    <= '0;
                  rsp_line_base_ff      <= '0;
                  rsp_line_last_byte_ff <= '0;
                  rsp_end_known_ff      <= 1'b0;
                  if (is_query_ff) begin
                     rsp_line_number_ff <= {1'b0, lo_ff} + {{(CNT_W-1){1'b0}}, 1'b1};
                     rsp_line_base_ff   <= lo_val_ff;
                     rsp_end_known_ff   <= next_seen_ff;
                     if (next_seen_ff) begin
                        rsp_line_last_byte_ff <= next_val_ff
                                                 - {{(START_W-1){1'b0}}, 1'b1};
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_line_number    = rsp_line_number_ff;
   assign rsp_line_base      = rsp_line_base_ff;
   assign rsp_line_last_byte = rsp_line_last_byte_ff;
   assign rsp_end_known      = rsp_end_known_ff;

   // entry count stays within one and the table depth
   `LOTL_ASSERT_IMP(a_count_range, clock, reset, 1'b1,
      (count_ff != '0) && (count_ff <= CNT_W'(MAX_LINES)))
   // an open search window has its probe strictly above lo and within hi
   `LOTL_ASSERT_IMP(a_window, clock, reset, state_ff == ST_SEARCH,
      (lo_ff < hi_ff) && (mid_ff > lo_ff) && (mid_ff <= hi_ff))
   // an accepted append that passes both checks grows the table by one
   `LOTL_ASSERT_NEXT(a_append_grows, clock, reset, req_beat && !req_mode && app_ok,
      count_ff == $past(count_ff) + CNT_W'(1))
   // a result beat is only launched from the finish state
   `LOTL_ASSERT_IMP(a_launch_src, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_FIN)

endmodule

// File: hw/rtl/lotl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lotl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sim/tb_line_offset_table_lookup.sv
// Self-checking testbench for line_offset_table_lookup: appends, lookups and order rejects.
module tb_line_offset_table_lookup
   import lotl_pkg::*;
();

   localparam logic MODE_APPEND  = 1'b0;
   localparam logic MODE_QUERY   = 1'b1;
   localparam int   TOP_OFFSET   = (1 << OFFSET_BITS) - 1;
   localparam int   FILL_TOP     = TOP_OFFSET - 1;
   localparam int   RANDOM_ITEMS = 1220;
   localparam int   REPORT_MAX   = 10;
   localparam int   CYCLE_LIMIT  = 200000;

   typedef struct {
      logic                   mode;
      logic [OFFSET_BITS-1:0] offset;
   } line_beat_type;

   typedef struct {
      logic [1:0]         status;
      logic [CNT_W-1:0]   line_number;
      logic [START_W-1:0] line_base;
      logic [START_W-1:0] line_last_byte;
      logic               end_known;
   } line_info_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_mode = MODE_APPEND;
   logic [OFFSET_BITS-1:0] req_offset = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_status;
   logic [CNT_W-1:0]       rsp_line_number;
   logic [START_W-1:0]     rsp_line_base;
   logic [START_W-1:0]     rsp_line_last_byte;
   logic                   rsp_end_known;

   // stimulus and expected results
   line_beat_type pending_beats[$];
   line_info_type expected_lines[$];
   int            plan_starts[$];
   int            plan_newest = 0;

   // predicted table contents
   logic [START_W-1:0] line_bases [MAX_LINES];
   int                 line_count = 1;
   logic [START_W-1:0] newest_line_base = '0;

   int  cycle_count = 0;
   int  problems = 0;
   int  appends_taken = 0;
   int  order_rejects = 0;
   int  full_rejects = 0;
   int  lookups_done = 0;
   logic req_fire = 1'b0;
   int  send_gap = 0;
   int  stall_left = 0;

   line_offset_table_lookup i_dut (.*);

   always #1 clock = ~clock;

   // Predict the result beat of one request and update the table copy.
   function automatic line_info_type predict_line(logic mode, logic [OFFSET_BITS-1:0] offset);
      line_info_type      info;
      logic [START_W-1:0] next_start;
      int                 lo;
      int                 hi;
      int                 mid;
      info.status         = STATUS_OK;
      info.line_number    = '0;
      info.line_base      = '0;
      info.line_last_byte = '0;
      info.end_known      = 1'b0;
      if (mode == MODE_APPEND) begin
         next_start = {1'b0, offset} + START_W'(1);
         if (next_start <= newest_line_base) begin
            info.status = STATUS_ORDER;
            order_rejects++;
         end else if (line_count >= MAX_LINES) begin
            info.status = STATUS_FULL;
            full_rejects++;
         end else begin
            line_bases[line_count] = next_start;
            line_count++;
            newest_line_base = next_start;
            appends_taken++;
         end
      end else begin
         // last entry not above the offset
         lo = 0;
         hi = line_count - 1;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (line_bases[mid] <= {1'b0, offset}) lo = mid;
            else hi = mid - 1;
         end
         info.line_number = CNT_W'(lo + 1);
         info.line_base   = line_bases[lo];
         if (lo + 1 < line_count) begin
            info.line_last_byte = line_bases[lo + 1] - START_W'(1);
            info.end_known      = 1'b1;
         end
         lookups_done++;
      end
      return info;
   endfunction

   // Queue one request; track planned starts so lookups can aim at boundaries.
   task automatic add_beat(logic mode, int offset);
      line_beat_type beat;
      beat.mode   = mode;
      beat.offset = OFFSET_BITS'(offset);
      pending_beats.push_back(beat);
      if (mode == MODE_APPEND && offset + 1 > plan_newest && plan_starts.size() < MAX_LINES) begin
         plan_starts.push_back(offset + 1);
         plan_newest = offset + 1;
      end
   endtask

   // Lookup offset: half the time on or just below a line start, else anywhere.
   function automatic int query_offset();
      int s;
      int r;
      s = plan_starts[$urandom_range(0, plan_starts.size() - 1)];
      case ($urandom_range(0, 9))
         0, 1, 2: r = s;
         3, 4:    r = (s == 0) ? 0 : s - 1;
         5, 6:    r = $urandom_range(0, plan_newest + 64);
         7:       r = $urandom_range(plan_newest, TOP_OFFSET);
         8:       r = $urandom_range(0, TOP_OFFSET);
         default: r = ($urandom_range(0, 1) == 1) ? TOP_OFFSET : 0;
      endcase
      return (r > TOP_OFFSET) ? TOP_OFFSET : r;
   endfunction

   // Idle bursts only in part of each window, and never in the tail of the run.
   function automatic bit idle_allowed();
      return ((cycle_count % 4000) < 2800) && (pending_beats.size() >= 400);
   endfunction

   // Request driver: payload holds while stalled.
   always @(negedge clock) begin
      line_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_beats.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            send_gap  <= $urandom_range(0, 6);
         end else begin
            beat = pending_beats.pop_front();
            req_valid  <= 1'b1;
            req_mode   <= beat.mode;
            req_offset <= beat.offset;
         end
      end
   end

   // Result side back-pressure in bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_allowed() && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: predict on accepted requests, check accepted results in order.
   always @(posedge clock) begin
      line_info_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall)
            expected_lines.push_back(predict_line(req_mode, req_offset));
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               if (problems < REPORT_MAX)
                  $display("cycle %0d: result beat with nothing expected", cycle_count);
               problems++;
            end else begin
               want = expected_lines.pop_front();
               if (rsp_status !== want.status || rsp_line_number !== want.line_number ||
                   rsp_line_base !== want.line_base ||
                   rsp_line_last_byte !== want.line_last_byte ||
                   rsp_end_known !== want.end_known) begin
                  if (problems < REPORT_MAX) begin
                     $display("cycle %0d: expected status %0d line %0d base %h last %h known %b",
                              cycle_count, want.status, want.line_number, want.line_base,
                              want.line_last_byte, want.end_known);
                     $display("cycle %0d: got      status %0d line %0d base %h last %h known %b",
                              cycle_count, rsp_status, rsp_line_number, rsp_line_base,
                              rsp_line_last_byte, rsp_end_known);
                  end
                  problems++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int pick;
      line_bases[0] = '0;
      plan_starts.push_back(0);

      // directed: single-line table, first appends, order rejects, boundaries
      add_beat(MODE_QUERY, 0);
      add_beat(MODE_QUERY, TOP_OFFSET);
      add_beat(MODE_APPEND, 0);
      add_beat(MODE_APPEND, 0);
      add_beat(MODE_QUERY, 0);
      add_beat(MODE_QUERY, 1);
      add_beat(MODE_APPEND, 99);
      add_beat(MODE_APPEND, 50);
      add_beat(MODE_APPEND, 99);
      add_beat(MODE_QUERY, 99);
      add_beat(MODE_QUERY, 100);
      add_beat(MODE_QUERY, TOP_OFFSET);
      add_beat(MODE_APPEND, 'hFFF);
      add_beat(MODE_QUERY, 'hFFF);
      add_beat(MODE_QUERY, 'h1000);

      // random mix: growing table, lookups, rejected appends
      repeat (RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) add_beat(MODE_APPEND, plan_newest + $urandom_range(0, 2999));
         else if (pick < 85) add_beat(MODE_QUERY, query_offset());
         else if (pick < 95) add_beat(MODE_APPEND, $urandom_range(0, plan_newest - 1));
         else add_beat(MODE_APPEND, plan_newest - 1);
      end

      // tail: start past the top offset, order rejects, lookups on the last line
      add_beat(MODE_APPEND, TOP_OFFSET);
      add_beat(MODE_APPEND, 0);
      add_beat(MODE_APPEND, FILL_TOP);
      add_beat(MODE_QUERY, TOP_OFFSET);
      add_beat(MODE_QUERY, FILL_TOP);
      add_beat(MODE_QUERY, 0);
      repeat (60) add_beat(MODE_QUERY, query_offset());

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_valid) @(posedge clock);
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run: %0d appends stored, %0d out-of-order and %0d full rejects, %0d lookups",
               appends_taken, order_rejects, full_rejects, lookups_done);
      $display("run: table ended with %0d lines after %0d cycles, %0d mismatches",
               line_count, cycle_count, problems);
      if (problems == 0 && expected_lines.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/lotl_pkg.sv
hw/rtl/lotl_ram.sv
hw/rtl/line_offset_table_lookup.sv
sim/tb_line_offset_table_lookup.sv
